FILE: rtl/mlfw_pkg.sv
// ----------------------------------------------------------------------------
// mlfw_pkg
// Shared types and constants for the hardware mutex with a FIFO wait queue:
// field widths, request kinds, outcome and target-state codes.
// ----------------------------------------------------------------------------
package mlfw_pkg;

   // Port field widths
   localparam int KIND_WIDTH    = 1;
   localparam int PID_WIDTH     = 8;
   localparam int OUTCOME_WIDTH = 3;
   localparam int TSTATE_WIDTH  = 2;
   localparam int COUNT_WIDTH   = 5;

   // Parameter defaults
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int PID_BITS_DEF    = 8;

   // Request kinds
   localparam logic [KIND_WIDTH-1:0] KIND_LOCK   = 1'b0;
   localparam logic [KIND_WIDTH-1:0] KIND_UNLOCK = 1'b1;

   typedef enum logic [OUTCOME_WIDTH-1:0] {
      OUT_ACQUIRED     = 3'd0,
      OUT_QUEUED       = 3'd1,
      OUT_RELOCK_ERROR = 3'd2,
      OUT_ALREADY_OPEN = 3'd3,
      OUT_HANDED_OFF   = 3'd4,
      OUT_RELEASED     = 3'd5,
      OUT_NOT_OWNER    = 3'd6,
      OUT_QUEUE_FULL   = 3'd7
   } outcome_type;

   typedef enum logic [TSTATE_WIDTH-1:0] {
      TS_UNCHANGED = 2'd0,
      TS_SLEEPING  = 2'd1,
      TS_READY     = 2'd2,
      TS_ZOMBIE    = 2'd3
   } tstate_type;

   // Queue operation requested by the decision logic
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

endpackage

FILE: rtl/mutex_lock_with_fifo_waiters.sv
// ----------------------------------------------------------------------------
// mutex_lock_with_fifo_waiters
// Hardware mutex with a FIFO of waiting process ids.
// ----------------------------------------------------------------------------
// A request (req_kind, req_pid) is taken on any clock edge where start is
// high; busy is always low, so one request per cycle is sustained. Each
// request gives exactly one response: the request is registered, decided
// against the lock and queue state in one pass of logic, and the response
// registered. rsp_strobe is high for exactly one cycle per response and
// the receiver cannot stall it, so it must take every response in the
// cycle it appears. Lock state, owner and waiting count on the response
// reflect the state after that request. Only the low PID_BITS bits of the
// process id take part.
// ----------------------------------------------------------------------------
module mutex_lock_with_fifo_waiters #(
   parameter int QUEUE_DEPTH = mlfw_pkg::QUEUE_DEPTH_DEF,
   parameter int PID_BITS    = mlfw_pkg::PID_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mlfw_pkg::KIND_WIDTH-1:0]     req_kind,
   input  logic [mlfw_pkg::PID_WIDTH-1:0]      req_pid,
   output logic                                rsp_strobe,
   output logic [mlfw_pkg::OUTCOME_WIDTH-1:0]  rsp_outcome,
   output logic [mlfw_pkg::PID_WIDTH-1:0]      rsp_target_pid,
   output logic [mlfw_pkg::TSTATE_WIDTH-1:0]   rsp_target_state,
   output logic                                rsp_lock_open,
   output logic [mlfw_pkg::PID_WIDTH-1:0]      rsp_owner_pid,
   output logic [mlfw_pkg::COUNT_WIDTH-1:0]    rsp_waiting_count
);
   import mlfw_pkg::*;

   localparam int PID_W    = (PID_BITS < PID_WIDTH) ? PID_BITS : PID_WIDTH;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Request register
   logic                  req_valid_ff;
   logic [KIND_WIDTH-1:0] req_kind_ff;
   logic [PID_W-1:0]      req_pid_ff;

   // Lock state
   logic             open_ff, open_in;
   logic [PID_W-1:0] holder_ff, holder_in;

   // Queue and decision wiring
   q_ctl_type           q_ctl;
   logic [PID_W-1:0]    head_pid;
   logic [CNT_BITS-1:0] count;
   logic [CNT_BITS-1:0] count_next;
   outcome_type         outcome;
   tstate_type          target_state;
   logic [PID_W-1:0]    target_pid;

   // Response register
   logic                    rsp_strobe_ff;
   logic [OUTCOME_WIDTH-1:0] rsp_outcome_ff;
   logic [PID_WIDTH-1:0]    rsp_target_pid_ff;
   logic [TSTATE_WIDTH-1:0] rsp_target_state_ff;
   logic                    rsp_lock_open_ff;
   logic [PID_WIDTH-1:0]    rsp_owner_pid_ff;
   logic [COUNT_WIDTH-1:0]  rsp_waiting_count_ff;

   assign busy = 1'b0;

   // Capture request on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_kind_ff <= req_kind;
      req_pid_ff  <= req_pid[PID_W-1:0];
   end

   mlfw_decide #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PID_W       (PID_W),
      .CNT_BITS    (CNT_BITS)
   ) u_decide (
      .valid        (req_valid_ff),
      .kind         (req_kind_ff),
      .pid          (req_pid_ff),
      .open         (open_ff),
      .holder       (holder_ff),
      .count        (count),
      .head_pid     (head_pid),
      .outcome      (outcome),
      .target_pid   (target_pid),
      .target_state (target_state),
      .open_next    (open_in),
      .holder_next  (holder_in),
      .q_ctl        (q_ctl)
   );

   mlfw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PID_W       (PID_W),
      .CNT_BITS    (CNT_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_ctl      (q_ctl),
      .wr_pid     (req_pid_ff),
      .head_pid   (head_pid),
      .count      (count),
      .count_next (count_next)
   );

   // Update lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b1;
         holder_ff <= '0;
      end else begin
         open_ff   <= open_in;
         holder_ff <= holder_in;
      end
   end

   // Register response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_outcome_ff       <= outcome;
      rsp_target_pid_ff    <= PID_WIDTH'(target_pid);
      rsp_target_state_ff  <= target_state;
      rsp_lock_open_ff     <= open_in;
      rsp_owner_pid_ff     <= PID_WIDTH'(holder_in);
      rsp_waiting_count_ff <= COUNT_WIDTH'(count_next);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_target_pid    = rsp_target_pid_ff;
   assign rsp_target_state  = rsp_target_state_ff;
   assign rsp_lock_open     = rsp_lock_open_ff;
   assign rsp_owner_pid     = rsp_owner_pid_ff;
   assign rsp_waiting_count = rsp_waiting_count_ff;

   // Checks
   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe)
      else $error("transfer without a response two cycles later");

   a_queued_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_outcome == OUT_QUEUED || rsp_outcome == OUT_QUEUE_FULL)
      |-> !rsp_lock_open)
      else $error("request queued or rejected while lock is open");

   a_handoff_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcome == OUT_HANDED_OFF
      |-> (rsp_owner_pid == rsp_target_pid) && !rsp_lock_open)
      else $error("handoff did not make the waiter the owner");

endmodule

FILE: rtl/mlfw_queue.sv
// ----------------------------------------------------------------------------
// mlfw_queue
// Circular FIFO of waiting process ids. Keeps head, tail and count, and
// prefetches the head entry into a register so it is ready for a handoff.
// ----------------------------------------------------------------------------
module mlfw_queue #(
   parameter int QUEUE_DEPTH = mlfw_pkg::QUEUE_DEPTH_DEF,
   parameter int PID_W       = mlfw_pkg::PID_BITS_DEF,
   parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mlfw_pkg::q_ctl_type  q_ctl,
   input  logic [PID_W-1:0]     wr_pid,
   output logic [PID_W-1:0]     head_pid,
   output logic [CNT_BITS-1:0]  count,
   output logic [CNT_BITS-1:0]  count_next
);
   import mlfw_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);

   logic [PID_W-1:0]    store_mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PID_W-1:0]    head_data_ff;

   // Advance pointers with wrap, track occupancy
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (q_ctl.pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      if (q_ctl.push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      case ({q_ctl.push, q_ctl.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Write at tail; prefetch the next head entry, forwarding a same-slot write
   always_ff @(posedge clock) begin
      if (q_ctl.push) begin
         store_mem[tail_ff] <= wr_pid;
      end
      if (q_ctl.push && (tail_ff == head_in)) begin
         head_data_ff <= wr_pid;
      end else begin
         head_data_ff <= store_mem[head_in];
      end
   end

   assign head_pid   = head_data_ff;
   assign count      = count_ff;
   assign count_next = count_in;

   // Checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_ctl.push && !q_ctl.pop |-> count_ff != CNT_BITS'(QUEUE_DEPTH))
      else $error("push into a full wait queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_ctl.pop |-> count_ff != '0)
      else $error("pop from an empty wait queue");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty wait queue with unequal head and tail");

endmodule

FILE: rtl/mlfw_decide.sv
// ----------------------------------------------------------------------------
// mlfw_decide
// Request decision logic: from the registered request and the current lock
// and queue state, pick the outcome, the target process and its new state,
// the next lock state and the queue operation.
// ----------------------------------------------------------------------------
module mlfw_decide #(
   parameter int QUEUE_DEPTH = mlfw_pkg::QUEUE_DEPTH_DEF,
   parameter int PID_W       = mlfw_pkg::PID_BITS_DEF,
   parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                        valid,
   input  logic [mlfw_pkg::KIND_WIDTH-1:0] kind,
   input  logic [PID_W-1:0]            pid,
   input  logic                        open,
   input  logic [PID_W-1:0]            holder,
   input  logic [CNT_BITS-1:0]         count,
   input  logic [PID_W-1:0]            head_pid,
   output mlfw_pkg::outcome_type       outcome,
   output logic [PID_W-1:0]            target_pid,
   output mlfw_pkg::tstate_type        target_state,
   output logic                        open_next,
   output logic [PID_W-1:0]            holder_next,
   output mlfw_pkg::q_ctl_type         q_ctl
);
   import mlfw_pkg::*;

   logic full;
   logic empty;

   assign full  = (count == CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count == '0);

   // Lock and unlock rules
   always_comb begin
      outcome      = OUT_ACQUIRED;
      target_pid   = pid;
      target_state = TS_UNCHANGED;
      open_next    = open;
      holder_next  = holder;
      q_ctl        = '0;
      if (valid) begin
         if (kind == KIND_LOCK) begin
            if (open) begin
               open_next   = 1'b0;
               holder_next = pid;
               outcome     = OUT_ACQUIRED;
            end else if (holder != pid) begin
               if (full) begin
                  outcome = OUT_QUEUE_FULL;
               end else begin
                  q_ctl.push   = 1'b1;
                  outcome      = OUT_QUEUED;
                  target_state = TS_SLEEPING;
               end
            end else begin
               open_next    = 1'b1;
               outcome      = OUT_RELOCK_ERROR;
               target_state = TS_ZOMBIE;
            end
         end else begin
            if (open) begin
               outcome = OUT_ALREADY_OPEN;
            end else if (!empty) begin
               q_ctl.pop    = 1'b1;
               target_pid   = head_pid;
               holder_next  = head_pid;
               outcome      = OUT_HANDED_OFF;
               target_state = TS_READY;
            end else if (holder == pid) begin
               open_next = 1'b1;
               outcome   = OUT_RELEASED;
            end else begin
               outcome      = OUT_NOT_OWNER;
               target_state = TS_ZOMBIE;
            end
         end
      end
   end

endmodule

FILE: test/tb_mutex_lock_with_fifo_waiters.sv
// ----------------------------------------------------------------------------
// tb_mutex_lock_with_fifo_waiters
// Self-checking bench for the hardware mutex with a FIFO wait queue. A clocked
// driver sends lock and unlock requests from a pending queue, with random
// sender gaps. A shadow mutex predicts every response at the transfer, and a
// clocked monitor compares each strobed response field by field, in order.
// ----------------------------------------------------------------------------
module tb_mutex_lock_with_fifo_waiters;
   timeunit 1ns;
   timeprecision 1ps;

   import mlfw_pkg::*;

   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 40000;

   typedef struct {
      logic [KIND_WIDTH-1:0] kind;
      logic [PID_WIDTH-1:0]  pid;
   } lock_req_type;

   typedef struct {
      outcome_type            outcome;
      logic [PID_WIDTH-1:0]   target_pid;
      tstate_type             target_state;
      logic                   lock_open;
      logic [PID_WIDTH-1:0]   owner_pid;
      logic [COUNT_WIDTH-1:0] waiting_count;
   } lock_rsp_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [KIND_WIDTH-1:0]    req_kind;
   logic [PID_WIDTH-1:0]     req_pid;
   logic                     rsp_strobe;
   logic [OUTCOME_WIDTH-1:0] rsp_outcome;
   logic [PID_WIDTH-1:0]     rsp_target_pid;
   logic [TSTATE_WIDTH-1:0]  rsp_target_state;
   logic                     rsp_lock_open;
   logic [PID_WIDTH-1:0]     rsp_owner_pid;
   logic [COUNT_WIDTH-1:0]   rsp_waiting_count;

   lock_req_type request_q[$];
   lock_rsp_type expected_rsp_q[$];
   int        total_requests;
   int        sent_count;
   int        fail_count;
   int        mismatch_count;
   int        cycle_count;

   // Shadow mutex state
   logic                   shadow_open;
   logic [PID_WIDTH-1:0]   shadow_holder;
   logic [PID_WIDTH-1:0]   shadow_waiters[DEPTH];
   int                     shadow_head;
   int                     shadow_tail;
   int                     shadow_count;

   mutex_lock_with_fifo_waiters DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_pid           (req_pid),
      .rsp_strobe        (rsp_strobe),
      .rsp_outcome       (rsp_outcome),
      .rsp_target_pid    (rsp_target_pid),
      .rsp_target_state  (rsp_target_state),
      .rsp_lock_open     (rsp_lock_open),
      .rsp_owner_pid     (rsp_owner_pid),
      .rsp_waiting_count (rsp_waiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the shadow mutex by one request and queue the response it gives
   task automatic predict_lock_rsp(input logic [KIND_WIDTH-1:0] kind,
                                   input logic [PID_WIDTH-1:0] pid);
      lock_rsp_type rsp;
      rsp.target_pid   = pid;
      rsp.target_state = TS_UNCHANGED;
      if (kind == KIND_LOCK) begin
         if (shadow_open) begin
            shadow_open   = 1'b0;
            shadow_holder = pid;
            rsp.outcome   = OUT_ACQUIRED;
         end else if (shadow_holder != pid) begin
            if (shadow_count >= DEPTH) begin
               rsp.outcome = OUT_QUEUE_FULL;
            end else begin
               shadow_waiters[shadow_tail] = pid;
               shadow_tail  = (shadow_tail == DEPTH - 1) ? 0 : shadow_tail + 1;
               shadow_count = shadow_count + 1;
               rsp.outcome      = OUT_QUEUED;
               rsp.target_state = TS_SLEEPING;
            end
         end else begin
            // owner locking again: lock opens, waiters stay queued
            shadow_open      = 1'b1;
            rsp.outcome      = OUT_RELOCK_ERROR;
            rsp.target_state = TS_ZOMBIE;
         end
      end else begin
         if (shadow_open) begin
            rsp.outcome = OUT_ALREADY_OPEN;
         end else if (shadow_count > 0) begin
            // hand off to the head waiter, no owner check
            rsp.target_pid   = shadow_waiters[shadow_head];
            shadow_head      = (shadow_head == DEPTH - 1) ? 0 : shadow_head + 1;
            shadow_count     = shadow_count - 1;
            shadow_holder    = rsp.target_pid;
            rsp.outcome      = OUT_HANDED_OFF;
            rsp.target_state = TS_READY;
         end else if (shadow_holder == pid) begin
            shadow_open = 1'b1;
            rsp.outcome = OUT_RELEASED;
         end else begin
            rsp.outcome      = OUT_NOT_OWNER;
            rsp.target_state = TS_ZOMBIE;
         end
      end
      rsp.lock_open     = shadow_open;
      rsp.owner_pid     = shadow_holder;
      rsp.waiting_count = shadow_count[COUNT_WIDTH-1:0];
      expected_rsp_q.insert(expected_rsp_q.size(), rsp);
   endtask

   function automatic void add_request(input logic [KIND_WIDTH-1:0] kind,
                                       input logic [PID_WIDTH-1:0] pid);
      lock_req_type r;
      r.kind = kind;
      r.pid  = pid;
      request_q.insert(request_q.size(), r);
   endfunction

   // Sender gap rate by phase: light, heavy, then none
   function automatic int sender_idle_pct();
      if (sent_count < total_requests / 3)
         return 24;
      else if (sent_count < (2 * total_requests) / 3)
         return 57;
      else
         return 0;
   endfunction

   // Driver: predict on each transfer, then present the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         start         <= 1'b0;
         shadow_open   = 1'b1;
         shadow_holder = '0;
         shadow_head   = 0;
         shadow_tail   = 0;
         shadow_count  = 0;
      end else begin
         if (start && !busy) begin
            predict_lock_rsp(req_kind, req_pid);
            sent_count = sent_count + 1;
         end
         if (!start || !busy) begin
            if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               start    <= 1'b1;
               req_kind <= request_q[0].kind;
               req_pid  <= request_q[0].pid;
               request_q.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed response with the oldest expectation
   always @(posedge clock) begin
      lock_rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            fail_count = fail_count + 1;
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display({"unexpected response: outcome %0d target %0h/%0d",
                         " open %0b owner %0h cnt %0d"},
                        rsp_outcome, rsp_target_pid, rsp_target_state, rsp_lock_open,
                        rsp_owner_pid, rsp_waiting_count);
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_outcome !== exp_rsp.outcome ||
                rsp_target_pid !== exp_rsp.target_pid ||
                rsp_target_state !== exp_rsp.target_state ||
                rsp_lock_open !== exp_rsp.lock_open ||
                rsp_owner_pid !== exp_rsp.owner_pid ||
                rsp_waiting_count !== exp_rsp.waiting_count) begin
               fail_count = fail_count + 1;
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display({"mismatch expected: outcome %0d target %0h/%0d",
                            " open %0b owner %0h cnt %0d"},
                           exp_rsp.outcome, exp_rsp.target_pid, exp_rsp.target_state,
                           exp_rsp.lock_open, exp_rsp.owner_pid, exp_rsp.waiting_count);
                  $display({"         actual:   outcome %0d target %0h/%0d",
                            " open %0b owner %0h cnt %0d"},
                           rsp_outcome, rsp_target_pid, rsp_target_state, rsp_lock_open,
                           rsp_owner_pid, rsp_waiting_count);
               end
            end
         end
      end
   end

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_mutex_lock_with_fifo_waiters NOT OK");
         $finish;
      end
   end

   initial begin
      int kind_pct;
      int seg_len;
      int seg_kind;
      int random_added;
      logic [PID_WIDTH-1:0] pool[4];
      logic [PID_WIDTH-1:0] base_pid;

      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_LOCK;
      req_pid        = '0;
      sent_count     = 0;
      fail_count     = 0;
      mismatch_count = 0;
      cycle_count    = 0;

      // Directed: every outcome and the pid extremes
      add_request(KIND_LOCK,   8'h00);   // acquire
      add_request(KIND_UNLOCK, 8'h00);   // release by owner
      add_request(KIND_UNLOCK, 8'hFF);   // unlock while open
      add_request(KIND_LOCK,   8'hFF);   // acquire
      add_request(KIND_LOCK,   8'hFF);   // owner relocks: zombie, lock opens
      add_request(KIND_LOCK,   8'hAA);   // acquire
      add_request(KIND_UNLOCK, 8'h55);   // not owner, no waiters
      for (int i = 0; i < DEPTH; i++)
         add_request(KIND_LOCK, (i == 0) ? 8'h00 : ((i == 1) ? 8'hFF : 8'(i * 37)));
      add_request(KIND_LOCK,   8'h77);   // queue full
      add_request(KIND_UNLOCK, 8'h33);   // handoff from a non-owner

      // Random: fill, drain and mixed segments over small pid pools, plus noise
      random_added = 0;
      while (random_added < RANDOM_ITEMS) begin
         for (int i = 0; i < 4; i++)
            pool[i] = 8'($urandom);
         seg_kind = $urandom_range(99);
         if (seg_kind < 30) begin
            // fill: one locker then others that differ from it, pushing toward a full queue
            seg_len  = $urandom_range(22, 12);
            base_pid = 8'($urandom);
            add_request(KIND_LOCK, base_pid);
            for (int i = 1; i < seg_len; i++)
               add_request(KIND_LOCK, base_pid + 8'($urandom_range(255, 1)));
         end else if (seg_kind < 55) begin
            // drain: unlocks by the pool members
            seg_len = $urandom_range(18, 6);
            for (int i = 0; i < seg_len; i++)
               add_request(KIND_UNLOCK, pool[$urandom_range(3)]);
         end else if (seg_kind < 90) begin
            // mixed: small pool so the owner often calls again
            seg_len  = $urandom_range(30, 10);
            kind_pct = $urandom_range(70, 30);
            for (int i = 0; i < seg_len; i++)
               add_request(($urandom_range(99) < kind_pct) ? KIND_LOCK : KIND_UNLOCK,
                           pool[$urandom_range(3)]);
         end else begin
            // noise: fully random requests
            seg_len = $urandom_range(8, 3);
            for (int i = 0; i < seg_len; i++)
               add_request(KIND_WIDTH'($urandom), 8'($urandom));
         end
         random_added = random_added + seg_len;
      end
      total_requests = request_q.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to transfer and every response to arrive
      do
         @(posedge clock);
      while (request_q.size() != 0 || start || expected_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_rsp_q.size() == 0)
         $display("tb_mutex_lock_with_fifo_waiters OK");
      else
         $display("tb_mutex_lock_with_fifo_waiters NOT OK");
      $finish;
   end

endmodule
